### rtl/cle_pkg.sv
package cle_pkg;

  localparam int StoreDepth = 128;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int QueueDepth = 2;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] KeyIgnore = 8'hff;
  localparam logic [7:0] KeyBs     = 8'h08;
  localparam logic [7:0] KeyCr     = 8'h0d;
  localparam logic [7:0] KeyNl     = 8'h0a;
  localparam logic [7:0] KeySq     = 8'h27;
  localparam logic [7:0] KeyDq     = 8'h22;
  localparam logic [7:0] KeySpace  = 8'h20;
  localparam logic [7:0] KeyLowA   = 8'h61;
  localparam logic [7:0] KeyLowZ   = 8'h7a;
  localparam logic [7:0] CaseShift = 8'h20;

  typedef enum logic [1:0] {
    OP_KEY   = 2'd0,
    OP_ARM   = 2'd1,
    OP_CLAIM = 2'd2,
    OP_READ  = 2'd3
  } cle_op_e;

  typedef enum logic [0:0] {
    CFG_LINE_CAPACITY = 1'b0,
    CFG_ECHO_ENABLE   = 1'b1
  } cle_cfg_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NEED = 2'd1,
    MODE_GOT  = 2'd2,
    MODE_EXEC = 2'd3
  } cle_mode_e;

  typedef enum logic [2:0] {
    CLS_ARM,
    CLS_CLAIM,
    CLS_READ,
    CLS_NEWLINE,
    CLS_ERASE,
    CLS_IGNORE,
    CLS_CHAR
  } cle_cls_e;

  typedef enum logic [2:0] {
    EX_RUN,
    EX_READ,
    EX_ERASE,
    EX_SPACE,
    EX_TAIL
  } cle_ex_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] key_byte;
    logic [6:0] read_index;
  } cle_req_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       last_of_run;
    logic       line_ready;
    logic [7:0] read_byte;
    logic [6:0] fill_level;
  } cle_rsp_t;

  typedef struct packed {
    cle_cls_e   cls;
    logic [7:0] data;
  } cle_cmd_t;

  function automatic logic [StoreAw-1:0] store_addr(logic [6:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[StoreAw-1:0];
  endfunction

  function automatic logic in_store(logic [6:0] v);
    return 32'(v) < StoreDepth;
  endfunction

  function automatic logic [6:0] effective_cap(logic [6:0] cap);
    logic [31:0] lim;
    lim = 32'(StoreDepth - 1);
    if (32'(cap) > lim) begin
      return lim[6:0];
    end
    return cap;
  endfunction

endpackage

### rtl/cle_front.sv
module cle_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_req_t in_req_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cle_pkg::cle_cmd_t cmd_o
);
  import cle_pkg::*;

  cle_cmd_t           slot_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]   count_q, count_d;
  cle_cmd_t           cls_cmd;
  logic               push, pop;

  // Classify the request so the executor only has to branch on a class code.
  always_comb begin
    cls_cmd.data = in_req_i.key_byte;
    case (cle_op_e'(in_req_i.operation))
      OP_ARM:   cls_cmd.cls = CLS_ARM;
      OP_CLAIM: cls_cmd.cls = CLS_CLAIM;
      OP_READ: begin
        cls_cmd.cls  = CLS_READ;
        cls_cmd.data = {1'b0, in_req_i.read_index};
      end
      OP_KEY: begin
        if (in_req_i.key_byte == KeyCr || in_req_i.key_byte == KeyNl) begin
          cls_cmd.cls = CLS_NEWLINE;
        end else if (in_req_i.key_byte == KeyBs) begin
          cls_cmd.cls = CLS_ERASE;
        end else if (in_req_i.key_byte == KeyIgnore) begin
          cls_cmd.cls = CLS_IGNORE;
        end else begin
          cls_cmd.cls = CLS_CHAR;
        end
      end
      default:  cls_cmd.cls = CLS_IGNORE;
    endcase
  end

  assign in_ready_o  = count_q != (QueueAw+1)'(QueueDepth);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls_cmd;
    end
  end

endmodule

### rtl/cle_back.sv
module cle_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cle_pkg::cle_cmd_t cmd_i,
  input  logic [6:0]        cap_i,
  input  logic              echo_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cle_pkg::cle_rsp_t out_rsp_o
);
  import cle_pkg::*;

  logic [7:0]         mem_q [StoreDepth];
  logic [7:0]         rdata_q;
  cle_ex_e            state_q, state_d;
  logic [6:0]         fill_q, fill_d;
  logic [7:0]         quote_q, quote_d;
  cle_mode_e          mode_q, mode_d;
  logic               out_valid_q, out_valid_d;
  cle_rsp_t           out_q, beat;
  logic               emit, can_emit;
  logic               we, re;
  logic [StoreAw-1:0] waddr, raddr;
  logic [7:0]         wdata, ch;

  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    quote_d     = quote_q;
    mode_d      = mode_q;
    we          = 1'b0;
    waddr       = store_addr(fill_q);
    wdata       = KeyNl;
    re          = 1'b0;
    raddr       = store_addr(cmd_i.data[6:0]);
    emit        = 1'b0;
    beat        = '0;
    cmd_ready_o = 1'b0;
    ch          = cmd_i.data;
    case (state_q)
      EX_RUN: begin
        cmd_ready_o = can_emit;
        if (cmd_valid_i && can_emit) begin
          beat.last_of_run = 1'b1;
          case (cmd_i.cls)
            CLS_ARM: begin
              mode_d  = MODE_NEED;
              fill_d  = '0;
              quote_d = '0;
              emit    = 1'b1;
            end
            CLS_CLAIM: begin
              if (mode_q == MODE_GOT) begin
                mode_d          = MODE_EXEC;
                beat.line_ready = 1'b1;
              end
              emit = 1'b1;
            end
            CLS_READ: begin
              // Move to the read state to wait for the registered read data.
              if (in_store(cmd_i.data[6:0])) begin
                re      = 1'b1;
                state_d = EX_READ;
              end else begin
                emit = 1'b1;
              end
            end
            CLS_NEWLINE: begin
              we     = in_store(fill_q);
              mode_d = MODE_GOT;
              if (echo_i) begin
                beat.echo_valid = 1'b1;
                beat.echo_char  = KeyNl;
              end
              emit = 1'b1;
            end
            CLS_ERASE: begin
              if (fill_q != '0) begin
                fill_d  = fill_q - 1'b1;
                re      = 1'b1;
                raddr   = store_addr(fill_q - 1'b1);
                state_d = EX_ERASE;
              end else begin
                emit = 1'b1;
              end
            end
            CLS_CHAR: begin
              if (fill_q < effective_cap(cap_i)) begin
                if (cmd_i.data == quote_q) begin
                  quote_d = '0;
                end else if (cmd_i.data == KeyDq || cmd_i.data == KeySq) begin
                  quote_d = cmd_i.data;
                end else if (quote_q == '0 && cmd_i.data >= KeyLowA &&
                             cmd_i.data <= KeyLowZ) begin
                  ch = cmd_i.data - CaseShift;
                end
                we     = 1'b1;
                wdata  = ch;
                fill_d = fill_q + 1'b1;
                if (echo_i) begin
                  beat.echo_valid = 1'b1;
                  beat.echo_char  = ch;
                end
              end
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      EX_READ: begin
        if (can_emit) begin
          beat.read_byte   = rdata_q;
          beat.last_of_run = 1'b1;
          emit             = 1'b1;
          state_d          = EX_RUN;
        end
      end
      EX_ERASE: begin
        if (can_emit) begin
          // Drop the quote state when the removed byte is the open quote.
          if (rdata_q == quote_q) begin
            quote_d = '0;
          end
          emit = 1'b1;
          if (echo_i) begin
            beat.echo_valid = 1'b1;
            beat.echo_char  = KeyBs;
            state_d         = EX_SPACE;
          end else begin
            beat.last_of_run = 1'b1;
            state_d          = EX_RUN;
          end
        end
      end
      EX_SPACE: begin
        if (can_emit) begin
          beat.echo_valid = 1'b1;
          beat.echo_char  = KeySpace;
          emit            = 1'b1;
          state_d         = EX_TAIL;
        end
      end
      EX_TAIL: begin
        if (can_emit) begin
          beat.echo_valid  = 1'b1;
          beat.echo_char   = KeyBs;
          beat.last_of_run = 1'b1;
          emit             = 1'b1;
          state_d          = EX_RUN;
        end
      end
      default: begin
        state_d = EX_RUN;
      end
    endcase
    beat.fill_level = fill_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EX_RUN;
      fill_q      <= '0;
      quote_q     <= '0;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      quote_q     <= quote_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### rtl/console_line_editor_top.sv
// Console line editor: requests carry keystrokes, arm, claim and read operations and
// each gives one response beat, or three for a backspace that removes a character
// while echo is on (0x08, space, 0x08). A front end classifies requests into a
// two-entry queue; the executor behind it owns the line store, fill, quote and mode
// state and a one-beat output register. Arm, claim, plain keystrokes and backspace on
// an empty line finish in the run state, so requests stream back to back while the
// output register is free. Reads and erasing backspaces wait in the read or erase
// state for the registered read port of the line store. The store comes up undefined;
// there is no clearing pass, so reading a position never written returns garbage.
// Write the configuration registers only while no request is outstanding.
module console_line_editor_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cle_pkg::cle_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cle_pkg::cle_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [0:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i
);
  import cle_pkg::*;

  logic [6:0] cap_q;
  logic       echo_q;
  logic       cmd_valid, cmd_ready;
  cle_cmd_t   cmd;

  // Configuration writes go straight into the registers; never stall them.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 7'd127;
      echo_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cle_cfg_e'(cfg_index_i))
        CFG_LINE_CAPACITY: cap_q  <= cfg_data_i;
        CFG_ECHO_ENABLE:   echo_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Accept and classify requests.
  cle_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_req_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Edit the line and emit response beats.
  cle_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .cap_i       (cap_q),
    .echo_i      (echo_q),
    .out_valid_o,
    .out_ready_i,
    .out_rsp_o
  );

  // With echo off no beat may carry a character.
  a_no_echo_when_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !echo_q |-> !out_rsp_o.echo_valid)
    else $error("echo beat while echo disabled");

  // Only the backspace echo sequence has beats before the last one.
  a_mid_beat_is_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.last_of_run |-> out_rsp_o.echo_valid)
    else $error("non-final beat without echo");

  // A claim hands over a line on a single silent beat.
  a_claim_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.line_ready |->
      out_rsp_o.last_of_run && !out_rsp_o.echo_valid && out_rsp_o.read_byte == '0)
    else $error("malformed claim beat");

endmodule
